### rtl/sorted_table_merge_by_insertion_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted table merge block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_MERGE_BY_INSERTION_DEFINES_SVH
`define SORTED_TABLE_MERGE_BY_INSERTION_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and off during reset.
`define STM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and off during reset.
`define STM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/stm_pkg.sv
// ----------------------------------------------------------------------------
// stm_pkg
// Word formats, command and status codes and sequencer states for the
// sorted table merge block.
// ----------------------------------------------------------------------------
package stm_pkg;

    localparam logic [2:0] CMD_CLEAR        = 3'd0;
    localparam logic [2:0] CMD_APPEND_LARGE = 3'd1;
    localparam logic [2:0] CMD_APPEND_SMALL = 3'd2;
    localparam logic [2:0] CMD_MERGE        = 3'd3;
    localparam logic [2:0] CMD_SEARCH       = 3'd4;
    localparam logic [2:0] CMD_READ         = 3'd5;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] key;
        logic [5:0]  index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [6:0]  position;
        logic [31:0] value;
        logic [6:0]  large_count;
    } t_out_item;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_SRCH_ISSUE,
        ST_SRCH_CMP,
        ST_MERGE_LOAD,
        ST_MERGE_KEY,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DONE
    } t_state;

endpackage

### rtl/sorted_table_merge_by_insertion.sv
// ----------------------------------------------------------------------------
// sorted_table_merge_by_insertion
// Sorted key table with a staging table, binary search and merge by
// binary insertion, one result word per command word.
// ----------------------------------------------------------------------------
// Every command runs alone; the input stalls until the result is built, and a
// finished result waits in an output register while the next command starts.
// All timing is set by the large-table memory (one registered read and one
// write per cycle) and the one shared key comparator. Clear, append and an
// out-of-range read go straight to the result; a good read waits for the
// registered memory word. A search runs an issue step and a compare step
// per probe. A merge fetches each staged key, runs the binary search for
// it, moves the large entries above its place up, then writes it in. Each
// large entry moves at most once in a merge. When the previous result is
// still stalled in the output register, the last cycle of a command
// repeats until that register frees.
// ----------------------------------------------------------------------------
module sorted_table_merge_by_insertion
    import stm_pkg::*;
#(
    parameter int LARGE_DEPTH = 64,
    parameter int SMALL_DEPTH = 16,
    parameter int KEY_BITS    = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    localparam int LAW = $clog2(LARGE_DEPTH);
    localparam int LCW = $clog2(LARGE_DEPTH + 1);
    localparam int SAW = (SMALL_DEPTH > 1) ? $clog2(SMALL_DEPTH) : 1;
    localparam int SCW = $clog2(SMALL_DEPTH + 1);

    // Tables
    logic [KEY_BITS-1:0] large_mem [LARGE_DEPTH];
    logic [KEY_BITS-1:0] small_mem [SMALL_DEPTH];
    logic [KEY_BITS-1:0] r_large_rd;
    logic [KEY_BITS-1:0] r_small_rd;

    logic                lg_we;
    logic [LAW-1:0]      lg_wa;
    logic [KEY_BITS-1:0] lg_wd;
    logic                lg_re;
    logic [LAW-1:0]      lg_ra;
    logic                sm_we;
    logic [SAW-1:0]      sm_wa;
    logic                sm_re;
    logic [SAW-1:0]      sm_ra;

    // Control state
    t_state         r_state, n_state;
    logic [LCW-1:0] r_large_used, n_large_used;
    logic [SCW-1:0] r_small_used, n_small_used;
    logic           r_signed;
    logic           r_is_merge, n_is_merge;
    logic           r_out_vld, n_out_vld;

    // Working registers
    logic [KEY_BITS-1:0] r_skey, n_skey;
    logic [LCW-1:0]      r_lo, n_lo;
    logic [LCW-1:0]      r_hp, n_hp;
    logic [LAW-1:0]      r_mid, n_mid;
    logic [LCW-1:0]      r_pos, n_pos;
    logic [LCW-1:0]      r_src, n_src;
    logic [LCW-1:0]      r_rest, n_rest;
    logic [SCW-1:0]      r_si, n_si;
    logic [1:0]          r_res_status, n_res_status;
    logic                r_res_found, n_res_found;
    logic [LCW-1:0]      r_res_pos, n_res_pos;
    logic [31:0]         r_res_value, n_res_value;
    t_out_item           r_out, n_out;

    // Helpers
    logic                accept;
    logic [63:0]         in_key_wide;
    logic [KEY_BITS-1:0] in_key;
    logic [31:0]         idx32;
    logic [31:0]         used32;
    logic [31:0]         small32;
    logic [31:0]         si32;
    logic [31:0]         src32;
    logic [31:0]         pos32;
    logic [31:0]         merge_sum32;
    logic [31:0]         wr_shift32;
    logic [31:0]         wr_ins32;
    logic [31:0]         small_ra32;
    logic [31:0]         res_pos32;
    logic [63:0]         rd_wide;
    logic [LCW:0]        mid_sum;
    logic [LCW:0]        mid_half;
    logic [LCW-1:0]      mid_ext;
    logic [LCW-1:0]      src_m1;
    logic                srch_open;
    logic                shift_more;
    t_cmp_res            cmp;

    stm_key_cmp #(
        .KEY_BITS (KEY_BITS)
    ) u_key_cmp (
        .i_a      (r_skey),
        .i_b      (r_large_rd),
        .i_signed (r_signed),
        .o_res    (cmp)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    assign accept      = i_in_valid && (r_state == ST_IDLE);
    assign in_key_wide = 64'(i_in_item.key);
    assign in_key      = in_key_wide[KEY_BITS-1:0];
    assign idx32       = 32'(i_in_item.index);
    assign used32      = 32'(r_large_used);
    assign small32     = 32'(r_small_used);
    assign si32        = 32'(r_si);
    assign src32       = 32'(r_src);
    assign pos32       = 32'(r_pos);
    assign merge_sum32 = used32 + small32;
    assign wr_shift32  = src32 - 32'd1 + si32;
    assign wr_ins32    = pos32 + si32 - 32'd1;
    assign small_ra32  = si32 - 32'd1;
    assign res_pos32   = 32'(r_res_pos);
    assign rd_wide     = 64'(r_large_rd);

    // Midpoint of lo and hi, with hi kept as hi+1.
    assign mid_sum     = {1'b0, r_lo} + {1'b0, r_hp} - (LCW + 1)'(1);
    assign mid_half    = mid_sum >> 1;
    assign mid_ext     = LCW'(r_mid);
    assign src_m1      = r_src - LCW'(1);
    assign srch_open   = (r_lo < r_hp);
    assign shift_more  = (r_src > r_pos);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_DONE;
                    if (i_in_item.command == CMD_SEARCH) begin
                        n_state = ST_SRCH_ISSUE;
                    end else if (i_in_item.command == CMD_READ && idx32 < used32) begin
                        n_state = ST_READ_WAIT;
                    end else if (i_in_item.command == CMD_MERGE
                                 && merge_sum32 <= 32'(LARGE_DEPTH)
                                 && r_small_used != '0) begin
                        n_state = ST_MERGE_LOAD;
                    end
                end
            end
            ST_READ_WAIT:  n_state = ST_DONE;
            ST_SRCH_ISSUE: begin
                if (srch_open) begin
                    n_state = ST_SRCH_CMP;
                end else begin
                    n_state = r_is_merge ? ST_SHIFT_RD : ST_DONE;
                end
            end
            ST_SRCH_CMP: begin
                if (cmp.eq) begin
                    n_state = r_is_merge ? ST_SHIFT_RD : ST_DONE;
                end else begin
                    n_state = ST_SRCH_ISSUE;
                end
            end
            ST_MERGE_LOAD: n_state = ST_MERGE_KEY;
            ST_MERGE_KEY:  n_state = ST_SRCH_ISSUE;
            ST_SHIFT_RD: begin
                if (shift_more) begin
                    n_state = ST_SHIFT_WR;
                end else if (r_si == SCW'(1)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MERGE_LOAD;
                end
            end
            ST_SHIFT_WR: n_state = ST_SHIFT_RD;
            ST_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_large_used = r_large_used;
        n_small_used = r_small_used;
        n_is_merge   = r_is_merge;
        n_skey       = r_skey;
        n_lo         = r_lo;
        n_hp         = r_hp;
        n_mid        = r_mid;
        n_pos        = r_pos;
        n_src        = r_src;
        n_rest       = r_rest;
        n_si         = r_si;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_pos    = r_res_pos;
        n_res_value  = r_res_value;
        n_out        = r_out;
        n_out_vld    = r_out_vld && i_out_stall;
        lg_we        = 1'b0;
        lg_wa        = used32[LAW-1:0];
        lg_wd        = in_key;
        lg_re        = 1'b0;
        lg_ra        = idx32[LAW-1:0];
        sm_we        = 1'b0;
        sm_wa        = small32[SAW-1:0];
        sm_re        = 1'b0;
        sm_ra        = small_ra32[SAW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res_status = STATUS_OK;
                    n_res_found  = 1'b0;
                    n_res_pos    = '0;
                    n_res_value  = '0;
                    n_is_merge   = 1'b0;
                    unique case (i_in_item.command)
                        CMD_CLEAR: begin
                            n_large_used = '0;
                            n_small_used = '0;
                        end
                        CMD_APPEND_LARGE: begin
                            if (used32 >= 32'(LARGE_DEPTH)) begin
                                n_res_status = STATUS_FULL;
                            end else begin
                                lg_we        = 1'b1;
                                n_large_used = r_large_used + LCW'(1);
                            end
                        end
                        CMD_APPEND_SMALL: begin
                            if (small32 >= 32'(SMALL_DEPTH)) begin
                                n_res_status = STATUS_FULL;
                            end else begin
                                sm_we        = 1'b1;
                                n_small_used = r_small_used + SCW'(1);
                            end
                        end
                        CMD_MERGE: begin
                            if (merge_sum32 > 32'(LARGE_DEPTH)) begin
                                n_res_status = STATUS_FULL;
                            end else begin
                                n_is_merge = 1'b1;
                                n_si       = r_small_used;
                                n_rest     = r_large_used;
                            end
                        end
                        CMD_SEARCH: begin
                            n_skey = in_key;
                            n_lo   = '0;
                            n_hp   = r_large_used;
                        end
                        CMD_READ: begin
                            if (idx32 >= used32) begin
                                n_res_status = STATUS_RANGE;
                            end else begin
                                lg_re = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ_WAIT: begin
                n_res_value = rd_wide[31:0];
            end
            ST_SRCH_ISSUE: begin
                if (srch_open) begin
                    lg_re = 1'b1;
                    lg_ra = mid_half[LAW-1:0];
                    n_mid = mid_half[LAW-1:0];
                end else begin
                    n_pos     = r_hp;
                    n_res_pos = r_hp;
                    n_src     = r_rest;
                end
            end
            ST_SRCH_CMP: begin
                if (cmp.eq) begin
                    n_pos       = mid_ext;
                    n_res_pos   = mid_ext;
                    n_res_found = 1'b1;
                    n_src       = r_rest;
                end else if (cmp.lt) begin
                    n_hp = mid_ext;
                end else begin
                    n_lo = mid_ext + LCW'(1);
                end
            end
            ST_MERGE_LOAD: begin
                sm_re = 1'b1;
            end
            ST_MERGE_KEY: begin
                n_skey = r_small_rd;
                n_lo   = '0;
                n_hp   = r_rest;
            end
            ST_SHIFT_RD: begin
                if (shift_more) begin
                    // Entries move up from the top down so none is overwritten early.
                    lg_re = 1'b1;
                    lg_ra = src_m1[LAW-1:0];
                end else begin
                    lg_we  = 1'b1;
                    lg_wa  = wr_ins32[LAW-1:0];
                    lg_wd  = r_skey;
                    n_rest = r_pos;
                    n_si   = r_si - SCW'(1);
                    if (r_si == SCW'(1)) begin
                        n_large_used = merge_sum32[LCW-1:0];
                        n_small_used = '0;
                        n_res_found  = 1'b0;
                        n_res_pos    = '0;
                    end
                end
            end
            ST_SHIFT_WR: begin
                lg_we = 1'b1;
                lg_wa = wr_shift32[LAW-1:0];
                lg_wd = r_large_rd;
                n_src = src_m1;
            end
            ST_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld           = 1'b1;
                    n_out.status        = r_res_status;
                    n_out.found         = r_res_found;
                    n_out.position      = res_pos32[6:0];
                    n_out.value         = r_res_value;
                    n_out.large_count   = used32[6:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (lg_we) begin
            large_mem[lg_wa] <= lg_wd;
        end
        if (lg_re) begin
            r_large_rd <= large_mem[lg_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sm_we) begin
            small_mem[sm_wa] <= in_key;
        end
        if (sm_re) begin
            r_small_rd <= small_mem[sm_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_large_used <= '0;
            r_small_used <= '0;
            r_signed     <= 1'b0;
            r_is_merge   <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_large_used <= n_large_used;
            r_small_used <= n_small_used;
            r_is_merge   <= n_is_merge;
            r_out_vld    <= n_out_vld;
            if (i_cfg_valid) begin
                r_signed <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_skey       <= n_skey;
        r_lo         <= n_lo;
        r_hp         <= n_hp;
        r_mid        <= n_mid;
        r_pos        <= n_pos;
        r_src        <= n_src;
        r_rest       <= n_rest;
        r_si         <= n_si;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_pos    <= n_res_pos;
        r_res_value  <= n_res_value;
        r_out        <= n_out;
    end

endmodule

### rtl/stm_key_cmp.sv
// ----------------------------------------------------------------------------
// stm_key_cmp
// Shared key comparator: orders two keys as unsigned or two's complement.
// ----------------------------------------------------------------------------
module stm_key_cmp
    import stm_pkg::*;
#(
    parameter int KEY_BITS = 32
) (
    input  logic [KEY_BITS-1:0] i_a,
    input  logic [KEY_BITS-1:0] i_b,
    input  logic                i_signed,
    output t_cmp_res            o_res
);

    logic [KEY_BITS-1:0] flip;
    logic [KEY_BITS-1:0] a_x;
    logic [KEY_BITS-1:0] b_x;

    // Flipping the sign bit turns a signed order into an unsigned one.
    always_comb begin
        flip               = '0;
        flip[KEY_BITS-1]   = i_signed;
        a_x                = i_a ^ flip;
        b_x                = i_b ^ flip;
        o_res.lt           = (a_x < b_x);
        o_res.eq           = (a_x == b_x);
    end

endmodule

### rtl/stm_checker.sv
// ----------------------------------------------------------------------------
// stm_checker
// Port-level checks for the sorted table merge block, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_table_merge_by_insertion_defines.svh"

module stm_checker
    import stm_pkg::*;
#(
    parameter int LARGE_DEPTH = 64
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_stall,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_item
);

    `STM_ASSERT_NEXT(a_out_hold, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_item), "result word changed while stalled")

    // The input stalls in the cycle after any command is taken.
    `STM_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !i_in_stall, i_in_stall, "input not stalled while a command is in progress")

    `STM_ASSERT_NOW(a_count_bound, i_out_valid, 32'(i_out_item.large_count) <= 32'(LARGE_DEPTH), "large count beyond table depth")

    `STM_ASSERT_NOW(a_found_ok, i_out_valid && i_out_item.found, i_out_item.status == STATUS_OK, "found flagged on an error result")

    `STM_ASSERT_NOW(a_error_clean, i_out_valid && i_out_item.status != STATUS_OK, i_out_item.value == 32'd0 && i_out_item.position == 7'd0, "error result carries data")

endmodule

bind sorted_table_merge_by_insertion stm_checker #(
    .LARGE_DEPTH (LARGE_DEPTH)
) u_stm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);
